>>> rtl/core/c3rb_pkg.sv
// ----------------------------------------------------------------------------
// c3rb_pkg: shared types and constants for the 3x3 replicate-border filter
// Payload structs, register index codes and fixed field widths.
// ----------------------------------------------------------------------------
package c3rb_pkg;

  // frame geometry
  localparam int WIDTH_MAX = 1024;
  localparam int ADDR_W    = $clog2(WIDTH_MAX);
  localparam int POS_W     = 10;
  localparam int FW_W      = 11;

  // data widths
  localparam int PIX_W  = 16;
  localparam int COEF_W = 16;
  localparam int PROD_W = PIX_W + COEF_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int SUM_W  = 36;
  localparam int CFG_W  = 3 * COEF_W;
  localparam int KSIZE  = 3;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_KERNEL_TOP    = 2'd1;
  localparam logic [1:0] REG_KERNEL_MIDDLE = 2'd2;
  localparam logic [1:0] REG_KERNEL_BOTTOM = 2'd3;

  // configuration reset values
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST   = 11'd64;
  localparam logic [CFG_W-1:0] KERNEL_MIDDLE_RST = 48'h0000_1000_0000;

  // input beat
  typedef struct packed {
    logic signed [PIX_W-1:0] pixel;
    logic                    start_of_frame;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [SUM_W-1:0] filtered;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    end_of_frame;
    logic                    last_of_run;
  } out_t;

  // position and flags that follow a result down the sum pipeline
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             eof;
    logic             last;
  } res_meta_t;

endpackage

>>> rtl/core/conv3x3_replicate_border_top.sv
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_top: streaming 3x3 filter with replicate padding
// Line store, 3x3 window, result sequencer and a registered multiply/sum path.
// ----------------------------------------------------------------------------
// Path: a pixel enters stage 1, and each of its results goes from the result sequencer
//   through the product register, the row-sum register and the output register in turn.
// Throughput: 1 pixel per cycle while each pixel yields at most one result and the
//   output does not stall; the result sequencer sends one result per cycle while the
//   product stage can take it, and a pixel with more results holds stage 1 until its last is sent.
// Reset: async active low; counters at (0,0), config at reset values, line store
//   contents undefined until written (no clearing pass).

module conv3x3_replicate_border_top
  import c3rb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic [FW_W-1:0]   frame_width_q;
  logic [CFG_W-1:0]  kern_q [KSIZE];

  logic [POS_W-1:0]  in_col_q, in_row_q;
  logic [FW_W-1:0]   w_eff;
  logic [POS_W-1:0]  wm1;
  logic              restart;
  logic [POS_W-1:0]  cur_i, cur_j, nxt_i, nxt_j;
  logic [3:0]        acc_mask;
  logic              acc;

  // stage 1: pixel plus line store read
  logic              s1_v_q;
  logic signed [PIX_W-1:0] s1_pix_q;
  logic [POS_W-1:0]  s1_i_q, s1_j_q;
  logic              s1_top_q;
  logic [3:0]        s1_mask_q;
  logic              s1_ready, s1_adv;

  logic [2*PIX_W-1:0] line_mem [WIDTH_MAX];
  logic [2*PIX_W-1:0] rd_raw_q, fwd_data_q, line_rd, wr_data;
  logic               fwd_q;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic signed [PIX_W-1:0] col_v [KSIZE];

  // window
  logic signed [PIX_W-1:0] win_q [KSIZE][KSIZE];

  // stage 2: result sequencer
  logic [3:0]        mask_q, mask_clr;
  logic [POS_W-1:0]  s2_i_q, s2_j_q;
  logic              sel_a, sel_b, s2_last, s2_emit, s2_ready;
  res_meta_t         s2_meta;
  logic signed [PROD_W-1:0] prod_d [KSIZE][KSIZE];

  // stage 3: products, stage 4: row sums, then output register
  logic              s3_v_q, s3_ready;
  logic signed [PROD_W-1:0] prod_q [KSIZE][KSIZE];
  res_meta_t         s3_meta_q;
  logic              s4_v_q, s4_ready;
  logic signed [RSUM_W-1:0] rsum_d [KSIZE];
  logic signed [RSUM_W-1:0] rsum_q [KSIZE];
  res_meta_t         s4_meta_q;
  logic              out_v_q, out_ready;
  out_t              out_q;

  // --------------------------------------------------------------------------
  // Handshake chain
  // --------------------------------------------------------------------------
  assign out_ready  = !out_v_q || !out_stall_i;
  assign s4_ready   = !s4_v_q || out_ready;
  assign s3_ready   = !s3_v_q || s4_ready;
  assign s2_emit    = (mask_q != 4'd0) && s3_ready;
  assign s2_ready   = (mask_q == 4'd0) || (s2_emit && s2_last);
  assign s1_adv     = s1_v_q && s2_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign acc        = in_valid_i && s1_ready;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FRAME_WIDTH_RST;
      kern_q[0]     <= '0;
      kern_q[1]     <= KERNEL_MIDDLE_RST;
      kern_q[2]     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:   frame_width_q <= cfg_data_i[FW_W-1:0];
        REG_KERNEL_TOP:    kern_q[0]     <= cfg_data_i;
        REG_KERNEL_MIDDLE: kern_q[1]     <= cfg_data_i;
        REG_KERNEL_BOTTOM: kern_q[2]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective width: zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = FW_W'(1);
    end else if (frame_width_q > FW_W'(WIDTH_MAX)) begin
      w_eff = FW_W'(WIDTH_MAX);
    end else begin
      w_eff = frame_width_q;
    end
  end
  assign wm1 = POS_W'(w_eff - FW_W'(1));

  // --------------------------------------------------------------------------
  // Position counters and result mask of the incoming pixel
  // --------------------------------------------------------------------------
  always_comb begin
    restart = in_data_i.start_of_frame ||
              ({1'b0, in_col_q} >= w_eff) || ({1'b0, in_row_q} >= w_eff);
    cur_j   = restart ? '0 : in_col_q;
    cur_i   = restart ? '0 : in_row_q;
    if ((FW_W'(cur_j) + FW_W'(1)) >= w_eff) begin
      nxt_j = '0;
      nxt_i = ((FW_W'(cur_i) + FW_W'(1)) >= w_eff) ? '0 : cur_i + POS_W'(1);
    end else begin
      nxt_j = cur_j + POS_W'(1);
      nxt_i = cur_i;
    end
    // bit order: (r-1,c-1) (r-1,c) (r,c-1) (r,c), relative to the pixel
    acc_mask[0] = (cur_i != '0) && (cur_j != '0);
    acc_mask[1] = (cur_i != '0) && (cur_j == wm1);
    acc_mask[2] = (cur_i == wm1) && (cur_j != '0);
    acc_mask[3] = (cur_i == wm1) && (cur_j == wm1);
  end

  // --------------------------------------------------------------------------
  // Line store: {upper, middle} per column, one read and one write per cycle
  // --------------------------------------------------------------------------
  assign rd_addr = ADDR_W'(cur_j);
  assign wr_addr = ADDR_W'(s1_j_q);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (acc) begin
      rd_raw_q <= line_mem[rd_addr];
    end
  end

  // bypass when the same column is written on the read edge (one-pixel rows)
  always_ff @(posedge clk_i) begin
    if (acc) begin
      fwd_q      <= s1_adv && (wr_addr == rd_addr);
      fwd_data_q <= wr_data;
    end
  end

  assign line_rd = fwd_q ? fwd_data_q : rd_raw_q;

  // new column of the window; row 0 replicates the pixel upward
  always_comb begin
    col_v[2] = s1_pix_q;
    col_v[1] = s1_top_q ? s1_pix_q : $signed(line_rd[PIX_W-1:0]);
    col_v[0] = s1_top_q ? s1_pix_q : $signed(line_rd[2*PIX_W-1:PIX_W]);
    wr_data  = {col_v[1], s1_pix_q};
  end

  // --------------------------------------------------------------------------
  // Stage 1 and counters
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      in_col_q <= '0;
      in_row_q <= '0;
    end else begin
      if (acc) begin
        s1_v_q   <= 1'b1;
        in_col_q <= nxt_j;
        in_row_q <= nxt_i;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= in_data_i.pixel;
      s1_i_q    <= cur_i;
      s1_j_q    <= cur_j;
      s1_top_q  <= (cur_i == '0);
      s1_mask_q <= acc_mask;
    end
  end

  // --------------------------------------------------------------------------
  // Window: shifts when a pixel leaves stage 1, refills at column 0
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int r = 0; r < KSIZE; r++) begin
        if (s1_j_q == '0) begin
          win_q[r][0] <= col_v[r];
          win_q[r][1] <= col_v[r];
        end else begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[r][2] <= col_v[r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: walk the pending results in row-major order
  // --------------------------------------------------------------------------
  always_comb begin
    sel_a    = !(mask_q[0] || mask_q[1]);
    sel_b    = sel_a ? !mask_q[2] : !mask_q[0];
    mask_clr = mask_q & ~(4'b0001 << {sel_a, sel_b});
    s2_last  = (mask_clr == 4'd0);
    s2_meta.row  = sel_a ? s2_i_q : s2_i_q - POS_W'(1);
    s2_meta.col  = sel_b ? s2_j_q : s2_j_q - POS_W'(1);
    s2_meta.eof  = sel_a && sel_b;
    s2_meta.last = s2_last;
  end

  // products with edge-clamped window taps
  always_comb begin
    logic [1:0] wr, wc;
    logic signed [COEF_W-1:0] cf;
    for (int kr = 0; kr < KSIZE; kr++) begin
      for (int kc = 0; kc < KSIZE; kc++) begin
        wr = (sel_a && kr < KSIZE - 1) ? 2'(kr + 1) : 2'(kr);
        wc = (sel_b && kc < KSIZE - 1) ? 2'(kc + 1) : 2'(kc);
        cf = $signed(kern_q[kr][kc*COEF_W +: COEF_W]);
        prod_d[kr][kc] = cf * win_q[wr][wc];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 4'd0;
    end else if (s1_adv) begin
      mask_q <= s1_mask_q;
    end else if (s2_emit) begin
      mask_q <= mask_clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_i_q <= s1_i_q;
      s2_j_q <= s1_j_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3, 4 and output register
  // --------------------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      rsum_d[r] = RSUM_W'(prod_q[r][0]) + RSUM_W'(prod_q[r][1]) + RSUM_W'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s3_ready) s3_v_q  <= s2_emit;
      if (s4_ready) s4_v_q  <= s3_v_q;
      if (out_ready) out_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_emit) begin
      prod_q    <= prod_d;
      s3_meta_q <= s2_meta;
    end
    if (s3_v_q && s4_ready) begin
      rsum_q    <= rsum_d;
      s4_meta_q <= s3_meta_q;
    end
    if (s4_v_q && out_ready) begin
      out_q.filtered     <= SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);
      out_q.out_row      <= s4_meta_q.row;
      out_q.out_col      <= s4_meta_q.col;
      out_q.end_of_frame <= s4_meta_q.eof;
      out_q.last_of_run  <= s4_meta_q.last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the frame's final result is always the last one of its pixel
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_frame |-> out_data_o.last_of_run)
    else $error("end_of_frame without last_of_run");

  // same-column write on the read edge must reach the next pixel
  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s1_adv && (wr_addr == rd_addr) |=> line_rd == $past(wr_data))
    else $error("line store bypass missed");

  // pending results hold while the product stage is blocked
  a_mask_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != 4'd0) && !s3_ready |=> $stable(mask_q))
    else $error("result sequencer advanced while blocked");

  // an empty stage 1 never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with empty stage 1");

endmodule
